@@ hw/rtl/spo_pkg.sv @@
// spo_pkg: shared types, constants and helper functions for the sine partial oscillator
// used by spo_div and sine_partial_oscillator; depends on nothing else
package spo_pkg;

  // default parameter values
  localparam int PHASE_BITS_DEF      = 24;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // field widths
  localparam int SR_W      = 18;
  localparam int RATE_W    = 33;                 // widest rate fed to the divider (Q.8 hertz)
  localparam int DEN_W     = SR_W + 8;           // sample rate in Q.8
  localparam logic [SR_W-1:0] SR_RESET = SR_W'(48000);

  // one input item
  typedef struct packed {
    logic signed [15:0] tremolo_depth;
    logic        [23:0] tremolo_rate_hz;
    logic        [15:0] loudness;
    logic signed [15:0] envelope;
    logic signed [15:0] vibrato_depth;
    logic        [23:0] vibrato_rate_hz;
    logic        [23:0] base_freq_hz;
    logic        [15:0] freq_env_factor;
    logic        [15:0] detune_factor;
    logic        [15:0] phase_offset;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic signed [15:0] wave_sample;
    logic signed [15:0] amplitude_out;
  } out_item_t;

  // quarter-wave sine entry r of a quarter of 2^qbits points, signed Q1.15
  function automatic logic [15:0] qsine_entry(input int unsigned r, input int unsigned qbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned y;
    x  = 64'(r) << (30 - qbits);
    x2 = (x * x) >> 30;
    p  = 64'd5026994;
    p  = 64'd85569306 - ((x2 * p) >> 30);
    p  = 64'd693598668 - ((x2 * p) >> 30);
    p  = 64'd1686629713 - ((x2 * p) >> 30);
    y  = (((x * p) >> 30) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (y > 64'd32767) y = 64'd32767;
    return 16'(y);
  endfunction

  // clamp to signed 16 bit
  function automatic logic signed [15:0] sat16(input logic signed [36:0] v);
    if (v > 37'sd32767) return 16'sh7fff;
    if (v < -37'sd32768) return 16'sh8000;
    return 16'(v);
  endfunction

endpackage

@@ hw/rtl/spo_div.sv @@
// spo_div: bit-serial restoring divider giving the phase step floor(num * 2^PB / den) mod 2^PB
// depends on spo_pkg
module spo_div
  import spo_pkg::*;
#(
  parameter int PB = PHASE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RATE_W-1:0] num,
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [PB-1:0]     quo
);

  localparam int STEPS = RATE_W + PB;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic                    busy_r;
  logic                    done_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [DEN_W-1:0]        rem_r;
  logic [STEPS-1:0]        dvd_r;
  logic [PB-1:0]           quo_r;
  logic [DEN_W:0]          rem_t;
  logic                    ge;

  // one trial subtraction per cycle while busy
  assign rem_t = {rem_r, dvd_r[STEPS-1]};
  assign ge    = rem_t >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvd_r  <= {num, PB'(0)};
      end else if (busy_r) begin
        rem_r <= ge ? DEN_W'(rem_t - {1'b0, den}) : rem_t[DEN_W-1:0];
        quo_r <= {quo_r[PB-2:0], ge};
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // zero sample rate gives no step
  assign done = done_r;
  assign quo  = (den == '0) ? '0 : quo_r;

endmodule

@@ hw/rtl/sine_partial_oscillator.sv @@
// sine_partial_oscillator: one sine partial with tremolo and vibrato, fixed point
// depends on spo_pkg and spo_div
//
//   port group | dir | handshake          | payload
//   in_        | in  | in_valid/in_ready  | in_item_t
//   out_       | out | out_valid/out_ready| out_item_t
//   cfg_       | in  | cfg_we             | sample_rate, 18 bit
//
// from one accept to the next, an item passes through the idle state, seven multiply steps,
// three phase steps on the shared bit-serial divider, the wave multiply and the output load.
// the single shared multiplier serves one multiply step at a time under the sequencer.
// in_ready is high only while idle; the output load waits while an earlier result is
// still held. synchronous reset clears the phases and restores the sample rate to 48000.
module sine_partial_oscillator
  import spo_pkg::*;
#(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [SR_W-1:0]  cfg_wdata
);

  localparam int PB   = PHASE_BITS;
  localparam int TB   = SINE_TABLE_BITS;
  localparam int QB   = TB - 2;
  localparam int QLEN = 1 << QB;

  typedef enum logic [3:0] {
    S_IDLE, S_TREM, S_LE, S_AMP, S_VIB, S_F1, S_F2, S_F3,
    S_DT, S_WT, S_DV, S_WV, S_DC, S_WC, S_WAVE, S_OUT
  } state_t;

  state_t             state_r;
  in_item_t           item_r;
  logic [SR_W-1:0]    sr_r;
  logic [PB-1:0]      trem_acc_r;
  logic [PB-1:0]      vib_acc_r;
  logic [PB-1:0]      car_acc_r;
  logic signed [15:0] trem_r;
  logic signed [15:0] vib_r;
  logic signed [31:0] le_r;
  logic signed [18:0] amp_r;
  logic [27:0]        f1_r;
  logic [31:0]        f2_r;
  logic [32:0]        f3_r;
  logic signed [15:0] wave_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  // quarter-wave sine table, built at elaboration
  logic signed [15:0] qtab [QLEN+1];
  for (genvar g = 0; g <= QLEN; g++) begin : g_qtab
    assign qtab[g] = qsine_entry(g, QB);
  end

  // sine lookup of the phase that the current step needs
  logic [PB-1:0]      look_ph;
  logic [TB-1:0]      idx;
  logic [QB:0]        xr;
  logic signed [15:0] sine_val;
  always_comb begin
    case (state_r)
      S_TREM:  look_ph = trem_acc_r;
      S_VIB:   look_ph = vib_acc_r;
      default: look_ph = car_acc_r + (PB'(item_r.phase_offset) << (PB - 16));
    endcase
    idx      = look_ph[PB-1 -: TB];
    xr       = idx[TB-2] ? ((QB+1)'(QLEN) - {1'b0, idx[QB-1:0]}) : {1'b0, idx[QB-1:0]};
    sine_val = idx[TB-1] ? -qtab[xr] : qtab[xr];
  end

  // shared multiplier operands
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod;
  always_comb begin
    case (state_r)
      S_TREM: begin mul_a = 34'(item_r.tremolo_depth); mul_b = 18'(sine_val); end
      S_LE:   begin mul_a = 34'(item_r.loudness); mul_b = 18'(item_r.envelope); end
      S_AMP:  begin mul_a = 34'(le_r); mul_b = 18'sd32768 + 18'(trem_r); end
      S_VIB:  begin mul_a = 34'(item_r.vibrato_depth); mul_b = 18'(sine_val); end
      S_F1:   begin mul_a = 34'(item_r.base_freq_hz); mul_b = 18'(item_r.freq_env_factor); end
      S_F2:   begin mul_a = 34'(f1_r); mul_b = 18'(item_r.detune_factor); end
      S_F3:   begin mul_a = 34'(f2_r); mul_b = 18'sd32768 + 18'(vib_r); end
      S_WAVE: begin mul_a = 34'(amp_r); mul_b = 18'(sine_val); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod = mul_a * mul_b;

  // divider shared by the three phase steps
  logic              div_start;
  logic [RATE_W-1:0] div_num;
  logic              div_done;
  logic [PB-1:0]     div_quo;
  always_comb begin
    case (state_r)
      S_DT:    div_num = RATE_W'(item_r.tremolo_rate_hz);
      S_DV:    div_num = RATE_W'(item_r.vibrato_rate_hz);
      default: div_num = f3_r;
    endcase
  end
  assign div_start = (state_r == S_DT) || (state_r == S_DV) || (state_r == S_DC);

  spo_div #(.PB(PB)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   ({sr_r, 8'b0}),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sequencer, phase state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sr_r        <= SR_RESET;
      trem_acc_r  <= '0;
      vib_acc_r   <= '0;
      car_acc_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) sr_r <= cfg_wdata;
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_item;
            state_r <= S_TREM;
          end
        end
        S_TREM: begin trem_r <= 16'(prod >>> 15); state_r <= S_LE; end
        S_LE:   begin le_r <= 32'(prod); state_r <= S_AMP; end
        S_AMP:  begin amp_r <= 19'(prod >>> 31); state_r <= S_VIB; end
        S_VIB:  begin vib_r <= 16'(prod >>> 15); state_r <= S_F1; end
        S_F1:   begin f1_r <= 28'(prod >>> 12); state_r <= S_F2; end
        S_F2:   begin f2_r <= 32'(prod >>> 12); state_r <= S_F3; end
        S_F3:   begin f3_r <= 33'(prod >>> 15); state_r <= S_DT; end
        S_DT:   state_r <= S_WT;
        S_WT: begin
          if (div_done) begin
            trem_acc_r <= trem_acc_r + div_quo;
            state_r    <= S_DV;
          end
        end
        S_DV:   state_r <= S_WV;
        S_WV: begin
          if (div_done) begin
            vib_acc_r <= vib_acc_r + div_quo;
            state_r   <= S_DC;
          end
        end
        S_DC:   state_r <= S_WC;
        S_WC: begin
          if (div_done) begin
            car_acc_r <= car_acc_r + div_quo;
            state_r   <= S_WAVE;
          end
        end
        S_WAVE: begin wave_r <= sat16(37'(prod >>> 15)); state_r <= S_OUT; end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_item_r.wave_sample   <= wave_r;
            out_item_r.amplitude_out <= sat16(37'(amp_r));
            out_valid_r              <= 1'b1;
            state_r                  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
